/* design/pfb_pkg.sv */
package pfb_pkg;

	typedef enum logic [2:0] {
		ACT_CLEAR_ALL = 3'd0,
		ACT_CLEAR_WIN = 3'd1,
		ACT_OPEN      = 3'd2,
		ACT_BLIT      = 3'd3,
		ACT_LINE      = 3'd4,
		ACT_RECT      = 3'd5,
		ACT_READ      = 3'd6,
		ACT_NONE      = 3'd7
	} action_t;

	localparam int ADDR_W = 17;
	localparam int SPAN_W = 11;
	localparam int CMD_DEPTH = 4;
	localparam int RES_DEPTH = 2;

	localparam logic [7:0] LINE_BYTE   = 8'h18;
	localparam logic [7:0] CORNER_TOP  = 8'hF8;
	localparam logic [7:0] CORNER_BOT  = 8'h1F;
	localparam logic [7:0] SIDE_BYTE   = 8'hFF;
	localparam logic [7:0] EDGE_TOP    = 8'h08;
	localparam logic [7:0] EDGE_BOT    = 8'h10;

	typedef struct packed {
		action_t           action;
		logic [9:0]        column;
		logic [9:0]        page_row;
		logic [9:0]        span_columns;
		logic [6:0]        span_pages;
		logic [7:0]        pixel_byte;
		logic              invert;
		logic              origin_in;
		logic [ADDR_W-1:0] base_addr;
		logic [SPAN_W-1:0] run_cols;
		logic [7:0]        run_pages;
	} cmd_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       in_range;
	} result_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] value;
	} rect_t;

	// later tests override earlier ones
	function automatic rect_t rect_byte(input logic [SPAN_W-1:0] i, input logic [7:0] j,
		input logic [9:0] w, input logic [6:0] p);
		rect_t r;
		logic fi, li, fj, lj;
		fi = (i == '0);
		li = (i == ({1'b0, w} - 11'd1));
		fj = (j == '0);
		lj = (j == ({1'b0, p} - 8'd1));
		r.hit = 1'b0;
		r.value = 8'h00;
		if (fi && fj) begin
			r.hit = 1'b1;
			r.value = CORNER_TOP;
		end
		if (li && fj) begin
			r.hit = 1'b1;
			r.value = CORNER_TOP;
		end
		if (fi && lj) begin
			r.hit = 1'b1;
			r.value = CORNER_BOT;
		end
		if (li && lj) begin
			r.hit = 1'b1;
			r.value = CORNER_BOT;
		end
		if ((fi || li) && !fj && !lj) begin
			r.hit = 1'b1;
			r.value = SIDE_BYTE;
		end
		if (!fi && !li && fj) begin
			r.hit = 1'b1;
			r.value = EDGE_TOP;
		end
		if (!fi && !li && lj) begin
			r.hit = 1'b1;
			r.value = EDGE_BOT;
		end
		return r;
	endfunction

endpackage

/* design/pfb_front.sv */
module pfb_front
	import pfb_pkg::*;
#(
	parameter int COLUMNS = 256,
	parameter int PAGES = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [2:0] action,
	input  logic [9:0] column,
	input  logic [9:0] page_row,
	input  logic [9:0] span_columns,
	input  logic [6:0] span_pages,
	input  logic [7:0] pixel_byte,
	input  logic       invert,
	input  logic       init_busy,
	output logic       cmd_valid,
	output cmd_t       cmd,
	input  logic       cmd_pop
);

	localparam int PW = $clog2(CMD_DEPTH);
	localparam logic [SPAN_W-1:0] COLS_W = SPAN_W'(COLUMNS);
	localparam logic [SPAN_W-1:0] PAGES_W = SPAN_W'(PAGES);
	localparam logic [7:0] PAGES_B = 8'(PAGES);
	localparam logic [PW:0] FULL_CNT = (PW + 1)'(CMD_DEPTH);

	cmd_t              fifo_q [CMD_DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [PW:0]       count_q;
	cmd_t              entry;
	logic              col_in;
	logic              page_in;
	logic              wr_en;
	logic [SPAN_W-1:0] col_room;
	logic [7:0]        page_room;
	logic [20:0]       prod;

	// classify the item and precompute its clipped extent and store address
	always_comb begin
		col_in = {1'b0, column} < COLS_W;
		page_in = {1'b0, page_row} < PAGES_W;
		col_room = COLS_W - {1'b0, column};
		page_room = PAGES_B - page_row[7:0];
		prod = 21'(page_row) * 21'(COLUMNS);
		entry.action = action_t'(action);
		entry.column = column;
		entry.page_row = page_row;
		entry.span_columns = span_columns;
		entry.span_pages = span_pages;
		entry.pixel_byte = pixel_byte;
		entry.invert = invert;
		entry.origin_in = col_in && page_in;
		entry.base_addr = prod[ADDR_W-1:0] + ADDR_W'(column);
		entry.run_cols = '0;
		entry.run_pages = '0;
		if (entry.action == ACT_CLEAR_ALL) begin
			entry.origin_in = 1'b1;
			entry.base_addr = '0;
			entry.run_cols = COLS_W;
			entry.run_pages = PAGES_B;
		end else if (col_in && page_in) begin
			entry.run_cols = ({1'b0, span_columns} < col_room) ? {1'b0, span_columns} : col_room;
			if (entry.action == ACT_LINE) begin
				entry.run_pages = 8'd1;
			end else begin
				entry.run_pages = ({1'b0, span_pages} < page_room) ? {1'b0, span_pages} : page_room;
			end
		end
	end

	assign full = (count_q == FULL_CNT) || init_busy;
	assign wr_en = push && !full;
	assign cmd_valid = (count_q != '0);
	assign cmd = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fifo_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !cmd_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!wr_en && cmd_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/pfb_back.sv */
module pfb_back
	import pfb_pkg::*;
#(
	parameter int COLUMNS = 256,
	parameter int PAGES = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cmd_valid,
	input  cmd_t    cmd,
	output logic    cmd_pop,
	output logic    init_busy,
	output logic    res_push,
	output result_t res,
	input  logic    res_full
);

	localparam int DEPTH = COLUMNS * PAGES;
	localparam int AW = $clog2(DEPTH);
	localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(COLUMNS);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
	localparam logic [SPAN_W-1:0] COLS_W = SPAN_W'(COLUMNS);
	localparam logic [SPAN_W-1:0] PAGES_W = SPAN_W'(PAGES);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_SWEEP,
		S_READ,
		S_DONE
	} state_t;

	state_t            state_q;
	cmd_t              cur_q;
	result_t           res_q;
	logic [7:0]        mem [DEPTH];
	logic [7:0]        rdata_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] row_addr_q;
	logic [ADDR_W-1:0] blit_row_q;
	logic [SPAN_W-1:0] i_q;
	logic [7:0]        j_q;
	logic [9:0]        win_col_q;
	logic [9:0]        win_page_q;
	logic [9:0]        win_width_q;
	logic [6:0]        win_pages_q;
	logic              win_inv_q;
	logic [9:0]        cur_col_q;
	logic [6:0]        cur_page_q;

	logic              single;
	logic              blit_active;
	logic              blit_hit;
	logic              blit_wrap;
	logic [SPAN_W-1:0] c_sum;
	logic [SPAN_W-1:0] p_sum;
	logic [SPAN_W-1:0] col_next;
	logic              i_last;
	logic              j_last;
	rect_t             rect;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [7:0]        mem_wdata;
	logic              rd_en;

	assign init_busy = (state_q == S_INIT);

	always_comb begin
		single = (cmd.action == ACT_BLIT) || (cmd.action == ACT_OPEN) || (cmd.action == ACT_NONE);
		cmd_pop = (state_q == S_IDLE) && cmd_valid && (!single || !res_full);
		blit_active = (win_width_q != '0) && (cur_page_q < win_pages_q);
		c_sum = {1'b0, win_col_q} + {1'b0, cur_col_q};
		p_sum = {1'b0, win_page_q} + SPAN_W'(cur_page_q);
		blit_hit = blit_active && (c_sum < COLS_W) && (p_sum < PAGES_W);
		col_next = {1'b0, cur_col_q} + 11'd1;
		blit_wrap = (col_next >= {1'b0, win_width_q});
		i_last = (i_q == (cur_q.run_cols - 11'd1));
		j_last = (j_q == (cur_q.run_pages - 8'd1));
		rect = rect_byte(i_q, j_q, cur_q.span_columns, cur_q.span_pages);
		rd_en = cmd_pop && (cmd.action == ACT_READ) && cmd.origin_in;

		mem_we = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = 8'h00;
		res_push = 1'b0;
		res = '0;
		unique case (state_q)
			S_INIT: begin
				mem_we = 1'b1;
			end
			S_SWEEP: begin
				unique case (cur_q.action)
					ACT_LINE: begin
						mem_we = 1'b1;
						mem_wdata = cur_q.invert ? ~LINE_BYTE : LINE_BYTE;
					end
					ACT_RECT: begin
						mem_we = rect.hit;
						mem_wdata = rect.value;
					end
					default: begin
						mem_we = 1'b1;
					end
				endcase
			end
			S_IDLE: begin
				if (cmd_pop && single) begin
					res_push = 1'b1;
					unique case (cmd.action)
						ACT_BLIT: begin
							res.in_range = blit_hit;
							mem_we = blit_hit;
							mem_waddr = blit_row_q + ADDR_W'(cur_col_q);
							mem_wdata = cmd.pixel_byte ^ {8{win_inv_q}};
						end
						ACT_OPEN: begin
							res.in_range = cmd.origin_in;
						end
						default: begin
							res.in_range = 1'b0;
						end
					endcase
				end
			end
			S_DONE: begin
				res_push = !res_full;
				res = res_q;
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr[AW-1:0]] <= mem_wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[cmd.base_addr[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			res_q <= '0;
			addr_q <= '0;
			row_addr_q <= '0;
			blit_row_q <= '0;
			i_q <= '0;
			j_q <= '0;
			win_col_q <= '0;
			win_page_q <= '0;
			win_width_q <= '0;
			win_pages_q <= '0;
			win_inv_q <= 1'b0;
			cur_col_q <= '0;
			cur_page_q <= '0;
		end else begin
			unique case (state_q)
				S_INIT: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == LAST_ADDR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_pop) begin
						unique case (cmd.action)
							ACT_BLIT: begin
								if (blit_active) begin
									if (blit_wrap) begin
										cur_col_q <= '0;
										cur_page_q <= cur_page_q + 1'b1;
										blit_row_q <= blit_row_q + ROW_STEP;
									end else begin
										cur_col_q <= col_next[9:0];
									end
								end
							end
							ACT_OPEN: begin
								win_col_q <= cmd.column;
								win_page_q <= cmd.page_row;
								win_width_q <= cmd.span_columns;
								win_pages_q <= cmd.span_pages;
								win_inv_q <= cmd.invert;
								cur_col_q <= '0;
								cur_page_q <= '0;
								blit_row_q <= cmd.base_addr;
							end
							ACT_NONE: begin
								state_q <= S_IDLE;
							end
							ACT_READ: begin
								state_q <= S_READ;
							end
							default: begin
								addr_q <= cmd.base_addr;
								row_addr_q <= cmd.base_addr;
								i_q <= '0;
								j_q <= '0;
								res_q <= '{read_byte: 8'h00, in_range: cmd.origin_in};
								if ((cmd.run_cols == '0) || (cmd.run_pages == '0)) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_SWEEP;
								end
							end
						endcase
					end
				end
				S_SWEEP: begin
					if (i_last) begin
						i_q <= '0;
						if (j_last) begin
							state_q <= S_DONE;
						end else begin
							j_q <= j_q + 1'b1;
							row_addr_q <= row_addr_q + ROW_STEP;
							addr_q <= row_addr_q + ROW_STEP;
						end
					end else begin
						i_q <= i_q + 1'b1;
						addr_q <= addr_q + 1'b1;
					end
				end
				S_READ: begin
					res_q <= '{read_byte: (cur_q.origin_in ? rdata_q : 8'h00),
						in_range: cur_q.origin_in};
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!res_full) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_push_space: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full) else $error("result transfer into a full queue");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid) else $error("command taken from an empty queue");
	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && state_q != S_IDLE) |-> (mem_waddr <= LAST_ADDR))
		else $error("store write beyond the last byte");
	a_sweep_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP) |-> ((i_q < cur_q.run_cols) && (j_q < cur_q.run_pages)))
		else $error("sweep counter past clipped window");
	a_done_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !res_full) |=> (state_q == S_IDLE))
		else $error("finished action did not return to idle");
`endif

endmodule

/* design/pfb_result_fifo.sv */
module pfb_result_fifo
	import pfb_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t data,
	output logic    full,
	input  logic    pop,
	output logic    empty,
	output result_t head
);

	localparam int PW = $clog2(RES_DEPTH);
	localparam logic [PW:0] FULL_CNT = (PW + 1)'(RES_DEPTH);

	result_t       fifo_q [RES_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;
	logic          wr_en;
	logic          rd_en;

	assign full = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign wr_en = push && !full;
	assign rd_en = pop && !empty;
	assign head = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fifo_q[wr_ptr_q] <= data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (!wr_en && rd_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/page_framebuffer_blitter_top.sv */
// open, blit byte and unused codes: result queued as the command is taken; read: via S_READ, S_DONE
// window clear, line and rectangle: one clipped byte of the area swept per cycle in S_SWEEP, then S_DONE
// clear all: one store byte written per cycle on the single write port
// blits, opens, unused codes: one per cycle while the result queue has room; others wait for idle
// reset: async, active low; afterwards a clearing pass zeroes the store
// while full stays high; window, cursor and queues come out of reset zero and empty
module page_framebuffer_blitter_top
	import pfb_pkg::*;
#(
	parameter int COLUMNS = 256,
	parameter int PAGES = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [2:0] action,
	input  logic [9:0] column,
	input  logic [9:0] page_row,
	input  logic [9:0] span_columns,
	input  logic [6:0] span_pages,
	input  logic [7:0] pixel_byte,
	input  logic       invert,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] read_byte,
	output logic       in_range
);

	logic    init_busy;
	logic    cmd_valid;
	logic    cmd_pop;
	cmd_t    cmd;
	logic    res_push;
	logic    res_full;
	result_t res;
	result_t head;

	pfb_front #(
		.COLUMNS(COLUMNS),
		.PAGES(PAGES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.action(action),
		.column(column),
		.page_row(page_row),
		.span_columns(span_columns),
		.span_pages(span_pages),
		.pixel_byte(pixel_byte),
		.invert(invert),
		.init_busy(init_busy),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_pop(cmd_pop)
	);

	pfb_back #(
		.COLUMNS(COLUMNS),
		.PAGES(PAGES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_pop(cmd_pop),
		.init_busy(init_busy),
		.res_push(res_push),
		.res(res),
		.res_full(res_full)
	);

	pfb_result_fifo u_result (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.data(res),
		.full(res_full),
		.pop(pop),
		.empty(empty),
		.head(head)
	);

	assign read_byte = head.read_byte;
	assign in_range = head.in_range;

endmodule

/* tb/page_framebuffer_blitter_top_tb.sv */
`timescale 1ns / 1ps

module page_framebuffer_blitter_top_tb;
	import pfb_pkg::*;

	localparam int COLUMNS = 256;
	localparam int PAGES = 32;
	localparam int STORE_BYTES = COLUMNS * PAGES;
	localparam int IDLE_LIMIT = 40000;
	localparam int RANDOM_ITEMS = 1500;
	localparam int MAX_REPORTS = 200;

	typedef struct packed {
		action_t    action;
		logic [9:0] column;
		logic [9:0] page_row;
		logic [9:0] span_columns;
		logic [6:0] span_pages;
		logic [7:0] pixel_byte;
		logic       invert;
	} draw_cmd_t;

	typedef struct packed {
		action_t    action;
		logic [7:0] read_byte;
		logic       in_range;
	} readback_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       pop = 1'b0;
	logic [2:0] action = '0;
	logic [9:0] column = '0;
	logic [9:0] page_row = '0;
	logic [9:0] span_columns = '0;
	logic [6:0] span_pages = '0;
	logic [7:0] pixel_byte = '0;
	logic       invert = 1'b0;
	logic       full;
	logic       empty;
	logic [7:0] read_byte;
	logic       in_range;

	draw_cmd_t cmd_queue[$];
	readback_t readback_queue[$];
	int        mismatch_count = 0;
	int        idle_cycles = 0;

	// expected display state
	logic [7:0] frame_model [0:STORE_BYTES-1];
	int         win_col, win_page, win_width, win_pages;
	logic       win_invert;
	int         cur_col, cur_page;

	page_framebuffer_blitter_top #(
		.COLUMNS(COLUMNS),
		.PAGES(PAGES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.action(action),
		.column(column),
		.page_row(page_row),
		.span_columns(span_columns),
		.span_pages(span_pages),
		.pixel_byte(pixel_byte),
		.invert(invert),
		.empty(empty),
		.pop(pop),
		.read_byte(read_byte),
		.in_range(in_range)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input action_t act, input int got,
		input int want);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t: %s mismatch on %s: got %0h, expected %0h", $realtime, act.name(),
				what, got, want);
	endtask

	task automatic render_cmd(input draw_cmd_t c, output readback_t r);
		int col, pg, sc, sp, i, j, icap, jcap;
		logic fi, li, fj, lj, hit;
		logic [7:0] v;
		col = c.column;
		pg = c.page_row;
		sc = c.span_columns;
		sp = c.span_pages;
		icap = (col < COLUMNS) ? ((sc < COLUMNS - col) ? sc : COLUMNS - col) : 0;
		jcap = (pg < PAGES) ? ((sp < PAGES - pg) ? sp : PAGES - pg) : 0;
		r.action = c.action;
		r.read_byte = 8'h00;
		r.in_range = 1'b0;
		case (c.action)
			ACT_CLEAR_ALL: begin
				for (i = 0; i < STORE_BYTES; i++)
					frame_model[i] = 8'h00;
				r.in_range = 1'b1;
			end
			ACT_CLEAR_WIN: begin
				for (j = 0; j < jcap; j++)
					for (i = 0; i < icap; i++)
						frame_model[(pg + j) * COLUMNS + col + i] = 8'h00;
				r.in_range = (col < COLUMNS) && (pg < PAGES);
			end
			ACT_OPEN: begin
				win_col = col;
				win_page = pg;
				win_width = sc;
				win_pages = sp;
				win_invert = c.invert;
				cur_col = 0;
				cur_page = 0;
				r.in_range = (col < COLUMNS) && (pg < PAGES);
			end
			ACT_BLIT: begin
				if (win_width != 0 && cur_page < win_pages) begin
					if (win_col + cur_col < COLUMNS && win_page + cur_page < PAGES) begin
						frame_model[(win_page + cur_page) * COLUMNS + win_col + cur_col] =
							win_invert ? ~c.pixel_byte : c.pixel_byte;
						r.in_range = 1'b1;
					end
					cur_col++;
					if (cur_col >= win_width) begin
						cur_col = 0;
						cur_page++;
					end
				end
			end
			ACT_LINE: begin
				if (pg < PAGES)
					for (i = 0; i < icap; i++)
						frame_model[pg * COLUMNS + col + i] = c.invert ? ~LINE_BYTE : LINE_BYTE;
				r.in_range = (col < COLUMNS) && (pg < PAGES);
			end
			ACT_RECT: begin
				for (i = 0; i < icap; i++) begin
					for (j = 0; j < jcap; j++) begin
						fi = (i == 0);
						li = (i == sc - 1);
						fj = (j == 0);
						lj = (j == sp - 1);
						// bottom row wins over top row when the rectangle is one page tall
						if (fi || li) begin
							hit = 1'b1;
							v = lj ? CORNER_BOT : (fj ? CORNER_TOP : SIDE_BYTE);
						end else begin
							hit = fj || lj;
							v = lj ? EDGE_BOT : EDGE_TOP;
						end
						if (hit)
							frame_model[(pg + j) * COLUMNS + col + i] = v;
					end
				end
				r.in_range = (col < COLUMNS) && (pg < PAGES);
			end
			ACT_READ: begin
				if (col < COLUMNS && pg < PAGES) begin
					r.read_byte = frame_model[pg * COLUMNS + col];
					r.in_range = 1'b1;
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic queue_cmd(input action_t a, input int col, input int pg, input int sc,
		input int sp, input int pix, input int inv);
		draw_cmd_t c;
		c.action = a;
		c.column = col[9:0];
		c.page_row = pg[9:0];
		c.span_columns = sc[9:0];
		c.span_pages = sp[6:0];
		c.pixel_byte = pix[7:0];
		c.invert = inv[0];
		cmd_queue.push_back(c);
	endtask

	function automatic int pick_column();
		case ($urandom_range(0, 9))
			0: return $urandom_range(COLUMNS - 8, COLUMNS + 8);
			1: return $urandom_range(0, 1023);
			default: return $urandom_range(0, COLUMNS - 1);
		endcase
	endfunction

	function automatic int pick_page();
		case ($urandom_range(0, 9))
			0: return $urandom_range(PAGES - 3, PAGES + 2);
			1: return $urandom_range(0, 1023);
			default: return $urandom_range(0, PAGES - 1);
		endcase
	endfunction

	// sender: bursts of random length with random gaps
	int        burst_left = 0;
	int        gap_left = 0;
	always @(negedge clk) begin : sender
		logic      drive;
		draw_cmd_t head;
		drive = 1'b0;
		if (arst_n) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (cmd_queue.size() > 0) begin
				drive = 1'b1;
				head = cmd_queue[0];
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end
		end
		push <= drive;
		if (drive) begin
			action <= head.action;
			column <= head.column;
			page_row <= head.page_row;
			span_columns <= head.span_columns;
			span_pages <= head.span_pages;
			pixel_byte <= head.pixel_byte;
			invert <= head.invert;
		end
	end

	// receiver: stall mask redrawn each time the phase counter wraps
	logic [15:0] stall_mask = 16'hFFFF;
	int          stall_phase = 0;
	always @(negedge clk) begin
		if (stall_phase == 0) begin
			case ($urandom_range(0, 3))
				0: stall_mask = 16'hFFFF;
				1: stall_mask = 16'h0001 << $urandom_range(0, 15);
				default: stall_mask = 16'($urandom()) | 16'h0100;
			endcase
		end
		pop <= stall_mask[stall_phase % 16];
		stall_phase = (stall_phase + 1) % 48;
	end

	always @(posedge clk) begin : scoreboard
		draw_cmd_t taken;
		readback_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (readback_queue.size() == 0) begin
					report_mismatch("result with nothing pending", ACT_NONE, read_byte, 0);
				end else begin
					want = readback_queue.pop_front();
					if (read_byte !== want.read_byte)
						report_mismatch("read_byte", want.action, read_byte, want.read_byte);
					if (in_range !== want.in_range)
						report_mismatch("in_range", want.action, in_range, want.in_range);
				end
			end
			if (push && !full) begin
				taken = cmd_queue.pop_front();
				render_cmd(taken, want);
				readback_queue.push_back(want);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int issued, sel, w, h, n, k, col, pg;
		action_t a;
		for (k = 0; k < STORE_BYTES; k++)
			frame_model[k] = 8'h00;
		win_col = 0;
		win_page = 0;
		win_width = 0;
		win_pages = 0;
		win_invert = 1'b0;
		cur_col = 0;
		cur_page = 0;

		queue_cmd(ACT_READ, 0, 0, 0, 0, 0, 0);
		queue_cmd(ACT_READ, 1023, 1023, 1023, 127, 255, 1);
		// window straddling the right and bottom edges, then one byte too many
		queue_cmd(ACT_OPEN, COLUMNS - 2, PAGES - 1, 4, 2, 0, 1);
		queue_cmd(ACT_BLIT, 0, 0, 0, 0, 8'h00, 0);
		queue_cmd(ACT_BLIT, 0, 0, 0, 0, 8'hFF, 0);
		queue_cmd(ACT_BLIT, 0, 0, 0, 0, 8'hA5, 0);
		queue_cmd(ACT_BLIT, 0, 0, 0, 0, 8'h5A, 0);
		queue_cmd(ACT_BLIT, 0, 0, 0, 0, 8'h01, 0);
		queue_cmd(ACT_BLIT, 0, 0, 0, 0, 8'h80, 0);
		queue_cmd(ACT_BLIT, 0, 0, 0, 0, 8'h3C, 0);
		queue_cmd(ACT_BLIT, 0, 0, 0, 0, 8'hC3, 0);
		queue_cmd(ACT_BLIT, 0, 0, 0, 0, 8'h77, 0);
		queue_cmd(ACT_READ, COLUMNS - 1, PAGES - 1, 0, 0, 0, 0);
		queue_cmd(ACT_LINE, COLUMNS - 6, 0, 10, 0, 0, 0);
		queue_cmd(ACT_LINE, 0, 1, 1023, 0, 0, 1);
		queue_cmd(ACT_RECT, 5, 5, 1, 1, 0, 1);
		queue_cmd(ACT_RECT, 8, 5, 1, 3, 0, 0);
		queue_cmd(ACT_RECT, 12, 5, 3, 1, 0, 0);
		queue_cmd(ACT_RECT, COLUMNS - 6, PAGES - 2, 20, 5, 0, 0);
		queue_cmd(ACT_RECT, 20, 5, 0, 4, 0, 0);
		queue_cmd(ACT_READ, 5, 5, 0, 0, 0, 0);
		queue_cmd(ACT_CLEAR_WIN, COLUMNS - 4, PAGES - 2, 8, 4, 0, 0);
		queue_cmd(ACT_OPEN, 3, 3, 0, 2, 0, 0);
		queue_cmd(ACT_BLIT, 0, 0, 0, 0, 8'h55, 0);
		queue_cmd(ACT_NONE, 1023, 1023, 1023, 127, 255, 1);
		queue_cmd(ACT_CLEAR_WIN, 0, 0, 1023, 127, 0, 1);
		queue_cmd(ACT_CLEAR_ALL, 0, 0, 0, 0, 0, 0);
		queue_cmd(ACT_READ, 5, 1, 0, 0, 0, 0);

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// hold back the random part until every directed transfer is checked
		while (cmd_queue.size() != 0 || readback_queue.size() != 0)
			@(posedge clk);

		issued = 0;
		while (issued < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 99);
			if (sel < 40) begin
				w = $urandom_range(1, 12);
				h = $urandom_range(1, 3);
				if ($urandom_range(0, 19) == 0) begin
					if ($urandom_range(0, 1))
						w = 0;
					else
						h = 0;
				end
				col = pick_column();
				pg = pick_page();
				queue_cmd(ACT_OPEN, col, pg, w, h, $urandom_range(0, 255), $urandom_range(0, 1));
				n = w * h + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
				for (k = 0; k < n; k++)
					queue_cmd(ACT_BLIT, $urandom_range(0, 1023), $urandom_range(0, 1023),
						$urandom_range(0, 1023), $urandom_range(0, 127), $urandom_range(0, 255),
						$urandom_range(0, 1));
				issued += 1 + w * h;
				n = $urandom_range(0, 2);
				for (k = 0; k < n; k++)
					queue_cmd(ACT_READ, col + $urandom_range(0, w), pg + $urandom_range(0, h),
						$urandom_range(0, 1023), $urandom_range(0, 127), $urandom_range(0, 255),
						$urandom_range(0, 1));
				issued += n;
			end else if (sel < 58 || (sel >= 89 && sel < 93)) begin
				queue_cmd(ACT_READ, pick_column(), pick_page(), $urandom_range(0, 1023),
					$urandom_range(0, 127), $urandom_range(0, 255), $urandom_range(0, 1));
				issued++;
			end else if (sel < 68) begin
				queue_cmd(ACT_LINE, pick_column(), pick_page(), $urandom_range(0, 24),
					$urandom_range(0, 127), $urandom_range(0, 255), $urandom_range(0, 1));
				issued++;
			end else if (sel < 78) begin
				queue_cmd(ACT_RECT, pick_column(), pick_page(), $urandom_range(0, 10),
					$urandom_range(0, 5), $urandom_range(0, 255), $urandom_range(0, 1));
				issued++;
			end else if (sel < 86) begin
				queue_cmd(ACT_CLEAR_WIN, pick_column(), pick_page(), $urandom_range(0, 16),
					$urandom_range(0, 4), $urandom_range(0, 255), $urandom_range(0, 1));
				issued++;
			end else if (sel < 88) begin
				case ($urandom_range(0, 2))
					0: a = ACT_CLEAR_WIN;
					1: a = ACT_LINE;
					default: a = ACT_RECT;
				endcase
				queue_cmd(a, $urandom_range(0, COLUMNS - 1), $urandom_range(0, PAGES - 1),
					$urandom_range(0, 1023), $urandom_range(0, 127), $urandom_range(0, 255),
					$urandom_range(0, 1));
				issued++;
			end else if (sel == 88) begin
				queue_cmd(ACT_CLEAR_ALL, $urandom_range(0, 1023), $urandom_range(0, 1023),
					$urandom_range(0, 1023), $urandom_range(0, 127), $urandom_range(0, 255),
					$urandom_range(0, 1));
				issued++;
			end else begin
				a = action_t'($urandom_range(0, 7));
				queue_cmd(a, $urandom_range(0, 1023), $urandom_range(0, 1023),
					$urandom_range(0, 1023), $urandom_range(0, 127), $urandom_range(0, 255),
					$urandom_range(0, 1));
				if (a != ACT_NONE)
					issued++;
			end
		end

		while (cmd_queue.size() != 0 || readback_queue.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
